// File: src/bsi_pkg.sv
// bsi_pkg: shared types and codes for the bounded stack with sorted insert
// used by bsi_cell, bsi_res_fifo and bounded_stack_sorted_insert
// no dependencies
package bsi_pkg;

  localparam int DATA_W = 32;
  localparam int FILL_W = 5;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_SORT = 2'd1,
    OP_POP  = 2'd2,
    OP_REV  = 2'd3
  } bsi_op_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic              push_en;
    logic              sort_en;
    logic              swap_en;
    logic              swap_par;
    logic [DATA_W-1:0] value;
  } bsi_ctl_t;

  // one result beat
  typedef struct packed {
    logic [DATA_W-1:0] popped;
    logic              empty_err;
    logic              full_err;
    logic [FILL_W-1:0] fill;
  } bsi_res_t;

endpackage

// File: src/bsi_cell.sv
// bsi_cell: one stack slot of the cell chain, holds one entry
// compares, shifts and swaps with its two neighbors; depends on bsi_pkg
module bsi_cell
  import bsi_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic              clk,
  input  bsi_ctl_t          ctl,
  input  logic [CNT_W-1:0]  cnt,
  input  logic [DATA_W-1:0] below_q,
  input  logic [DATA_W-1:0] above_q,
  input  logic              below_in_run,
  input  logic              run_in,
  output logic [DATA_W-1:0] q,
  output logic              in_run,
  output logic              run_out
);

  localparam bit ODD       = (IDX % 2) == 1;
  localparam bit HAS_BELOW = IDX > 0;

  logic              occ;
  logic              top_slot;
  logic              gt;
  logic              lower_swap;
  logic              upper_swap;
  logic [DATA_W-1:0] q_next;

  assign occ      = CNT_W'(IDX) < cnt;
  assign top_slot = cnt == CNT_W'(IDX);
  assign gt       = $signed(q) > $signed(ctl.value);

  // run of greater entries grows down from the top; empty slots pass it on
  assign run_out = run_in & (~occ | gt);
  assign in_run  = run_in & occ & gt;

  // odd-even transposition pairs, both partners must be occupied
  assign lower_swap = (ODD == ctl.swap_par) && (CNT_W'(IDX + 1) < cnt);
  assign upper_swap = HAS_BELOW && (ODD != ctl.swap_par) && occ;

  always_comb begin
    q_next = q;
    if (ctl.push_en) begin
      if (top_slot) q_next = ctl.value;
    end else if (ctl.sort_en) begin
      if ((occ | top_slot) & below_in_run) begin
        q_next = below_q;
      end else if (in_run | top_slot) begin
        q_next = ctl.value;
      end
    end else if (ctl.swap_en) begin
      if (lower_swap) begin
        q_next = above_q;
      end else if (upper_swap) begin
        q_next = below_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// File: src/bsi_res_fifo.sv
// bsi_res_fifo: two-beat result queue in front of the master port
// lets a new beat enter while the previous one still waits; depends on bsi_pkg
module bsi_res_fifo
  import bsi_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr,
  input  bsi_res_t din,
  output logic     full,
  input  logic     rd_ready,
  output logic     rd_valid,
  output bsi_res_t dout
);

  logic [1:0] occ;
  bsi_res_t   e0;
  bsi_res_t   e1;
  logic       rd;

  assign rd       = rd_valid & rd_ready;
  assign rd_valid = occ != 2'd0;
  assign full     = occ == 2'd2;
  assign dout     = e0;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 2'd0;
    end else begin
      occ <= occ + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (rd) begin
      if (wr && occ == 2'd1) begin
        e0 <= din;
      end else begin
        e0 <= e1;
      end
      if (wr && occ == 2'd2) e1 <= din;
    end else if (wr) begin
      if (occ == 2'd0) begin
        e0 <= din;
      end else begin
        e1 <= din;
      end
    end
  end

endmodule

// File: src/bounded_stack_sorted_insert.sv
// bounded_stack_sorted_insert: top level of the bounded lifo stack with sorted insert
// builds the chain of bsi_cell slots and the bsi_res_fifo result queue; depends on bsi_pkg
//
//  port group | dir | tdata (low bit up)                    | tuser (low bit up)
//  s_*        | in  | value[31:0]                           | operation[1:0]
//  m_*        | out | popped_value[31:0], fill_count[36:32] | empty_error, full_error
//
// one input beat is taken per cycle for push, sorted push and pop; each gives one result
// beat that enters the result queue at the same edge
// reverse with two or more entries keeps s_tready low after its beat while
// the cell chain runs count rounds of odd-even neighbor swaps
// s_tready also drops while the two-beat result queue is full (m_tready held low)
// reset clears the count, the reverse state and the queue; entries are not cleared, no sweep
module bounded_stack_sorted_insert
  import bsi_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // value[31:0]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // popped_value[31:0], fill_count[36:32], zero pad
  output logic [1:0]  m_tuser    // empty_error[0], full_error[1]
);

  localparam int CW = $clog2(DEPTH + 1);  // count width, holds DEPTH itself
  localparam int IW = $clog2(DEPTH);      // entry index width

  // stack control
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          busy;     // reverse rounds in progress
  logic          par;      // parity of the current swap round
  logic [CW-1:0] rem;      // swap rounds left, including this one

  logic          acc;
  bsi_op_t       op;
  logic          is_full;
  logic          is_empty;
  bsi_ctl_t      ctl;
  bsi_res_t      res;
  bsi_res_t      out_res;
  logic          q_full;

  logic [DATA_W-1:0] q_arr [DEPTH];
  logic              run_dn [DEPTH];
  logic              ir [DEPTH];
  logic [IW-1:0]     top_idx;

  assign op       = bsi_op_t'(s_tuser);
  assign s_tready = ~busy & ~q_full;
  assign acc      = s_tvalid & s_tready;
  assign is_full  = cnt == CW'(DEPTH);
  assign is_empty = cnt == '0;
  assign top_idx  = IW'(cnt - 1'b1);

  // broadcast to the cells: one operation per accepted beat, swaps while busy
  assign ctl.push_en  = acc && op == OP_PUSH;
  assign ctl.sort_en  = acc && op == OP_SORT;
  assign ctl.swap_en  = busy;
  assign ctl.swap_par = par;
  assign ctl.value    = s_tdata;

  // decode: new count and flags of the result beat
  always_comb begin
    cnt_next      = cnt;
    res.popped    = '0;
    res.empty_err = 1'b0;
    res.full_err  = 1'b0;
    unique case (op)
      OP_PUSH, OP_SORT: begin
        // full stack: push drops the value, sorted push may discard the top
        if (is_full) begin
          res.full_err = 1'b1;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      OP_POP: begin
        if (is_empty) begin
          res.empty_err = 1'b1;
        end else begin
          cnt_next   = cnt - 1'b1;
          res.popped = q_arr[top_idx];
        end
      end
      OP_REV: begin
        // count unchanged, the result goes out before the swap rounds end
      end
      default: begin
      end
    endcase
    res.fill = FILL_W'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b0;
      par  <= 1'b0;
      rem  <= '0;
    end else begin
      if (acc) cnt <= cnt_next;
      if (acc && op == OP_REV && cnt > CW'(1)) begin
        busy <= 1'b1;
        par  <= 1'b0;
        rem  <= cnt;
      end else if (busy) begin
        par <= ~par;
        rem <= rem - 1'b1;
        if (rem == CW'(1)) busy <= 1'b0;
      end
    end
  end

  // chain of cells, cell 0 is the bottom of the stack
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] bq;
    logic [DATA_W-1:0] aq;
    logic              b_run;
    logic              r_in;

    if (g == 0) begin : g_bot
      assign bq    = '0;
      assign b_run = 1'b0;
    end else begin : g_mid_lo
      assign bq    = q_arr[g-1];
      assign b_run = ir[g-1];
    end

    if (g == DEPTH - 1) begin : g_top
      assign aq   = '0;
      assign r_in = 1'b1;
    end else begin : g_mid_hi
      assign aq   = q_arr[g+1];
      assign r_in = run_dn[g+1];
    end

    bsi_cell #(
      .IDX   (g),
      .CNT_W (CW)
    ) u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .cnt          (cnt),
      .below_q      (bq),
      .above_q      (aq),
      .below_in_run (b_run),
      .run_in       (r_in),
      .q            (q_arr[g]),
      .in_run       (ir[g]),
      .run_out      (run_dn[g])
    );
  end

  bsi_res_fifo u_res_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (acc),
    .din      (res),
    .full     (q_full),
    .rd_ready (m_tready),
    .rd_valid (m_tvalid),
    .dout     (out_res)
  );

  assign m_tdata = {3'b000, out_res.fill, out_res.popped};
  assign m_tuser = {out_res.full_err, out_res.empty_err};

`ifndef ASSERT_OFF
  // count never runs past the depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("stack count beyond depth");

  // reverse of two or more entries blocks the input on the next cycle
  a_rev_block: assert property (@(posedge clk) disable iff (rst)
    (acc && op == OP_REV && cnt > CW'(1)) |=> !s_tready)
    else $error("input not held off during reverse");

  // swap rounds leave the count alone
  a_swap_cnt: assert property (@(posedge clk) disable iff (rst) busy |=> $stable(cnt))
    else $error("count changed during reverse");

  // every accepted beat leaves a result waiting
  a_res_out: assert property (@(posedge clk) disable iff (rst) acc |=> m_tvalid)
    else $error("result beat missing after accept");
`endif

endmodule
